// ===== rtl/core/iecdev_pkg.sv =====
// ----------------------------------------------------------------------------
// iecdev_pkg: shared types and constants for the serial bus device
// Holds the beat structs, phase enum, contexts, event codes and defaults.
// ----------------------------------------------------------------------------
package iecdev_pkg;

  localparam int unsigned CMD_MAX_LEN_DEF = 32;

  localparam logic [7:0] CODE_LISTEN   = 8'h20;
  localparam logic [7:0] CODE_TALK     = 8'h40;
  localparam logic [7:0] CODE_UNLISTEN = 8'h3F;
  localparam logic [7:0] CODE_DATA     = 8'h60;
  localparam logic [7:0] CODE_HI_MASK  = 8'hF0;
  localparam logic [17:0] ATN_PRE_TICKS = 18'd50;
  localparam logic [17:0] TIMER_CAP     = 18'h3FFFF;

  // Register indexes.
  localparam logic [2:0] REG_DEVNUM   = 3'd0;
  localparam logic [2:0] REG_BIT      = 3'd1;
  localparam logic [2:0] REG_EOI_DET  = 3'd2;
  localparam logic [2:0] REG_EOI_SIG  = 3'd3;
  localparam logic [2:0] REG_NO_EOI   = 3'd4;
  localparam logic [2:0] REG_STABLE   = 3'd5;
  localparam logic [2:0] REG_ATN_DLY  = 3'd6;
  localparam logic [2:0] REG_TIMEOUT  = 3'd7;

  // Actions.
  localparam logic [1:0] ACT_SEND     = 2'd1;
  localparam logic [1:0] ACT_SEND_EOI = 2'd2;

  // Events.
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_LISTEN = 3'd1;
  localparam logic [2:0] EV_TALK   = 3'd2;
  localparam logic [2:0] EV_CMD    = 3'd3;
  localparam logic [2:0] EV_ERROR  = 3'd4;
  localparam logic [2:0] EV_SENT   = 3'd5;

  typedef enum logic [1:0] {ROLE_IDLE, ROLE_LISTEN, ROLE_TALK} role_t;
  typedef enum logic [2:0] {CX_PRIMARY, CX_SEC_LISTEN, CX_SEC_TALK, CX_COMMAND,
                            CX_DATA} ctx_t;

  typedef enum logic [4:0] {
    P_IDLE, P_LISTEN_READY, P_TALK_READY, P_ATN_PRE, P_RX_WAIT_READY,
    P_RX_EOI_TIME, P_RX_EOI_ACK, P_RX_EOI_CLK, P_RX_BIT_HIGH, P_RX_BIT_LOW,
    P_TURN_WAIT, P_TURN_1, P_TURN_2, P_SKIP_DELAY, P_SKIP_WAIT_ATN,
    P_POST_DELAY, P_TX_WAIT_ACCEPT, P_TX_WAIT_READY, P_TX_EOI_PAUSE,
    P_TX_EOI_LO, P_TX_EOI_HI, P_TX_PRE, P_TX_BIT_LO, P_TX_BIT_HI,
    P_TX_STABLE, P_TX_WAIT_ACK, P_UNDO_1, P_UNDO_2, P_UNDO_WAIT, P_ERR_WAIT
  } phase_t;

  typedef struct packed {
    logic       atn_low;
    logic       clock_low;
    logic       data_low;
    logic [1:0] action;
    logic [7:0] tx_byte;
  } in_beat_t;

  typedef struct packed {
    logic       drive_clock_low;
    logic       drive_data_low;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_eoi;
    logic       rx_is_command;
    logic [2:0] event_res;
    logic [7:0] secondary_code;
    logic       busy_res;
  } out_beat_t;

  typedef struct packed {
    logic [4:0]  device_number;
    logic [7:0]  bit_ticks;
    logic [9:0]  eoi_detect_ticks;
    logic [9:0]  eoi_signal_ticks;
    logic [7:0]  no_eoi_ticks;
    logic [7:0]  stable_ticks;
    logic [9:0]  atn_delay_ticks;
    logic [17:0] timeout_ticks;
  } cfg_t;

endpackage

// ===== rtl/core/iecdev_regs.sv =====
// ----------------------------------------------------------------------------
// iecdev_regs: configuration register file
// APB-style write and read of the eight timing and address registers.
// ----------------------------------------------------------------------------
module iecdev_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output iecdev_pkg::cfg_t    cfg
);
  import iecdev_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register write on the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_number    <= 5'd4;
      cfg_r.bit_ticks        <= 8'd70;
      cfg_r.eoi_detect_ticks <= 10'd200;
      cfg_r.eoi_signal_ticks <= 10'd200;
      cfg_r.no_eoi_ticks     <= 8'd20;
      cfg_r.stable_ticks     <= 8'd30;
      cfg_r.atn_delay_ticks  <= 10'd100;
      cfg_r.timeout_ticks    <= 18'd195000;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_DEVNUM:  cfg_r.device_number    <= pwdata[4:0];
        REG_BIT:     cfg_r.bit_ticks        <= pwdata[7:0];
        REG_EOI_DET: cfg_r.eoi_detect_ticks <= pwdata[9:0];
        REG_EOI_SIG: cfg_r.eoi_signal_ticks <= pwdata[9:0];
        REG_NO_EOI:  cfg_r.no_eoi_ticks     <= pwdata[7:0];
        REG_STABLE:  cfg_r.stable_ticks     <= pwdata[7:0];
        REG_ATN_DLY: cfg_r.atn_delay_ticks  <= pwdata[9:0];
        REG_TIMEOUT: cfg_r.timeout_ticks    <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (idx)
      REG_DEVNUM:  prdata = {27'd0, cfg_r.device_number};
      REG_BIT:     prdata = {24'd0, cfg_r.bit_ticks};
      REG_EOI_DET: prdata = {22'd0, cfg_r.eoi_detect_ticks};
      REG_EOI_SIG: prdata = {22'd0, cfg_r.eoi_signal_ticks};
      REG_NO_EOI:  prdata = {24'd0, cfg_r.no_eoi_ticks};
      REG_STABLE:  prdata = {24'd0, cfg_r.stable_ticks};
      REG_ATN_DLY: prdata = {22'd0, cfg_r.atn_delay_ticks};
      REG_TIMEOUT: prdata = {14'd0, cfg_r.timeout_ticks};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/core/iec_serial_bus_device.sv =====
// ----------------------------------------------------------------------------
// iec_serial_bus_device: device side of the serial bus
// Protocol engine stepped once per accepted sample beat.
//
//   channel | direction | beat
//   in_     | input     | one line sample tick plus send request
//   out_    | output    | one line drive and status beat per tick
//   cfg_    | APB       | eight timing and address registers
//
// Each input beat yields one output beat in the next cycle; one per cycle
// while out_ does not stall, set by the combinational phase update between
// the state registers and the output register. Reset is synchronous; state
// and registers return to their defaults. A stall on out_ holds the result
// and stalls in_ only when the output register is full and not being taken.
// ----------------------------------------------------------------------------
module iec_serial_bus_device #(
  parameter int unsigned CMD_MAX_LEN = iecdev_pkg::CMD_MAX_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  iecdev_pkg::in_beat_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output iecdev_pkg::out_beat_t out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import iecdev_pkg::*;

  cfg_t cfg;

  iecdev_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  // State registers.
  phase_t      phase_r, phase_nxt;
  role_t       role_r, role_nxt, post_role_r, post_role_nxt;
  ctx_t        ctx_r, ctx_nxt;
  logic [7:0]  shift_r, shift_nxt, cmdlen_r, cmdlen_nxt, sec_r, sec_nxt;
  logic [3:0]  bitcnt_r, bitcnt_nxt;
  logic [17:0] timer_r, timer_nxt, tinc;
  logic        eoi_r, eoi_nxt, atns_r, atns_nxt, peoi_r, peoi_nxt;
  logic        dclk_r, dclk_nxt, ddat_r, ddat_nxt;
  logic [2:0]  pev_r, pev_nxt;
  out_beat_t   res, out_r;
  logic        ov_r, step;

  logic atn, lclk, dat;
  assign atn  = in_data.atn_low;
  assign lclk = in_data.clock_low;
  assign dat  = in_data.data_low;

  assign in_stall  = ov_r && out_stall;
  assign step      = in_valid && !in_stall;
  assign out_valid = ov_r;
  assign out_data  = out_r;

  // Saturating wait counter value after this tick.
  assign tinc = (timer_r < TIMER_CAP) ? timer_r + 18'd1 : timer_r;

  // Next state of the protocol engine.
  always_comb begin
    logic [7:0] c;
    logic       to;
    logic [3:0] bc;
    phase_nxt = phase_r; role_nxt = role_r; post_role_nxt = post_role_r;
    ctx_nxt = ctx_r; shift_nxt = shift_r; cmdlen_nxt = cmdlen_r; sec_nxt = sec_r;
    bitcnt_nxt = bitcnt_r; timer_nxt = tinc; eoi_nxt = eoi_r; atns_nxt = atns_r;
    peoi_nxt = peoi_r; dclk_nxt = dclk_r; ddat_nxt = ddat_r; pev_nxt = pev_r;
    res = '0;
    c  = shift_r;
    to = (tinc >= cfg.timeout_ticks);
    bc = bitcnt_r + 4'd1;
    unique case (phase_r)
      P_IDLE: begin
        dclk_nxt = 1'b0; ddat_nxt = 1'b0;
        if (atn) begin
          ddat_nxt = 1'b1; phase_nxt = P_ATN_PRE; timer_nxt = '0;
        end
      end
      P_LISTEN_READY: begin
        dclk_nxt = 1'b0; ddat_nxt = 1'b1;
        if (atn) begin
          phase_nxt = P_ATN_PRE; timer_nxt = '0;
        end else if (!lclk) begin
          ctx_nxt = CX_DATA; eoi_nxt = 1'b0; atns_nxt = 1'b0;
          ddat_nxt = 1'b0; phase_nxt = P_RX_EOI_TIME; timer_nxt = '0;
        end
      end
      P_TALK_READY: begin
        dclk_nxt = 1'b1; ddat_nxt = 1'b0;
        if (atn) begin
          dclk_nxt = 1'b0; ddat_nxt = 1'b1; phase_nxt = P_ATN_PRE; timer_nxt = '0;
        end else if (in_data.action == ACT_SEND || in_data.action == ACT_SEND_EOI) begin
          shift_nxt = in_data.tx_byte; peoi_nxt = (in_data.action == ACT_SEND_EOI);
          phase_nxt = P_TX_WAIT_ACCEPT; timer_nxt = '0;
        end
      end
      P_ATN_PRE:
        if (tinc >= ATN_PRE_TICKS) begin
          ctx_nxt = CX_PRIMARY; eoi_nxt = 1'b0; atns_nxt = 1'b0;
          phase_nxt = P_RX_WAIT_READY; timer_nxt = '0;
        end
      P_RX_WAIT_READY:
        if (!lclk) begin
          ddat_nxt = 1'b0; phase_nxt = P_RX_EOI_TIME; timer_nxt = '0;
        end else if (to) phase_nxt = P_ERR_WAIT;
      P_RX_EOI_TIME:
        if (lclk) begin
          atns_nxt = atn; bitcnt_nxt = '0; shift_nxt = '0;
          phase_nxt = P_RX_BIT_HIGH; timer_nxt = '0;
        end else if (tinc >= 18'(cfg.eoi_detect_ticks)) begin
          eoi_nxt = 1'b1; ddat_nxt = 1'b1; phase_nxt = P_RX_EOI_ACK; timer_nxt = '0;
        end
      P_RX_EOI_ACK:
        if (tinc >= 18'(cfg.bit_ticks)) begin
          ddat_nxt = 1'b0; phase_nxt = P_RX_EOI_CLK; timer_nxt = '0;
        end
      P_RX_EOI_CLK:
        if (lclk) begin
          atns_nxt = atn; bitcnt_nxt = '0; shift_nxt = '0;
          phase_nxt = P_RX_BIT_HIGH; timer_nxt = '0;
        end else if (to) phase_nxt = P_ERR_WAIT;
      P_RX_BIT_HIGH:
        if (!lclk) begin
          shift_nxt = {~dat, shift_r[7:1]}; phase_nxt = P_RX_BIT_LOW; timer_nxt = '0;
        end else if (to) phase_nxt = P_ERR_WAIT;
      P_RX_BIT_LOW:
        if (lclk) begin
          bitcnt_nxt = bc; timer_nxt = '0;
          if (bc >= 4'd8) begin
            ddat_nxt = 1'b1;
            unique case (ctx_r)
              CX_PRIMARY:
                if (c == (CODE_LISTEN | {3'd0, cfg.device_number})) begin
                  ctx_nxt = CX_SEC_LISTEN; eoi_nxt = 1'b0; atns_nxt = 1'b0;
                  phase_nxt = P_RX_WAIT_READY;
                end else if (c == (CODE_TALK | {3'd0, cfg.device_number})) begin
                  ctx_nxt = CX_SEC_TALK; eoi_nxt = 1'b0; atns_nxt = 1'b0;
                  phase_nxt = P_RX_WAIT_READY;
                end else phase_nxt = P_SKIP_DELAY;
              CX_SEC_LISTEN: begin
                sec_nxt = c;
                if ((c & CODE_HI_MASK) == CODE_DATA) begin
                  pev_nxt = EV_LISTEN; post_role_nxt = ROLE_LISTEN;
                  phase_nxt = P_POST_DELAY;
                end else if (c != CODE_UNLISTEN) begin
                  cmdlen_nxt = '0; ctx_nxt = CX_COMMAND; eoi_nxt = 1'b0;
                  atns_nxt = 1'b0; phase_nxt = P_RX_WAIT_READY;
                end else begin
                  pev_nxt = EV_NONE; post_role_nxt = ROLE_IDLE;
                  phase_nxt = P_POST_DELAY;
                end
              end
              CX_SEC_TALK: begin
                sec_nxt = c; phase_nxt = P_TURN_WAIT;
              end
              CX_COMMAND:
                if (atns_r && c == CODE_UNLISTEN) begin
                  pev_nxt = EV_CMD; post_role_nxt = ROLE_IDLE;
                  phase_nxt = P_POST_DELAY;
                end else if (32'(cmdlen_r) >= CMD_MAX_LEN) begin
                  phase_nxt = P_ERR_WAIT;
                end else begin
                  cmdlen_nxt = cmdlen_r + 8'd1;
                  res.rx_valid = 1'b1; res.rx_byte = c; res.rx_eoi = eoi_r;
                  res.rx_is_command = 1'b1;
                  eoi_nxt = 1'b0; atns_nxt = 1'b0; phase_nxt = P_RX_WAIT_READY;
                end
              default: begin
                res.rx_valid = 1'b1; res.rx_byte = c; res.rx_eoi = eoi_r;
                if (eoi_r) begin
                  role_nxt = ROLE_IDLE; phase_nxt = P_IDLE;
                end else phase_nxt = P_LISTEN_READY;
              end
            endcase
          end else phase_nxt = P_RX_BIT_HIGH;
        end else if (to) phase_nxt = P_ERR_WAIT;
      P_TURN_WAIT:
        if (!lclk) begin
          ddat_nxt = 1'b0; phase_nxt = P_TURN_1; timer_nxt = '0;
        end else if (to) phase_nxt = P_ERR_WAIT;
      P_TURN_1:
        if (tinc >= 18'(cfg.bit_ticks)) begin
          dclk_nxt = 1'b1; phase_nxt = P_TURN_2; timer_nxt = '0;
        end
      P_TURN_2:
        if (tinc >= 18'(cfg.bit_ticks)) begin
          pev_nxt = EV_TALK; post_role_nxt = ROLE_TALK;
          phase_nxt = P_POST_DELAY; timer_nxt = '0;
        end
      P_SKIP_DELAY:
        if (tinc >= 18'(cfg.atn_delay_ticks)) begin
          dclk_nxt = 1'b0; ddat_nxt = 1'b0; phase_nxt = P_SKIP_WAIT_ATN;
          timer_nxt = '0;
        end
      P_SKIP_WAIT_ATN:
        if (!atn) begin
          role_nxt = ROLE_IDLE; pev_nxt = EV_NONE; post_role_nxt = ROLE_IDLE;
          phase_nxt = P_POST_DELAY; timer_nxt = '0;
        end
      P_POST_DELAY:
        if (tinc >= 18'(cfg.atn_delay_ticks)) begin
          res.event_res = pev_r; role_nxt = post_role_r; timer_nxt = '0;
          unique case (post_role_r)
            ROLE_LISTEN: begin
              dclk_nxt = 1'b0; ddat_nxt = 1'b1; phase_nxt = P_LISTEN_READY;
            end
            ROLE_TALK: begin
              dclk_nxt = 1'b1; ddat_nxt = 1'b0; phase_nxt = P_TALK_READY;
            end
            default: begin
              dclk_nxt = 1'b0; ddat_nxt = 1'b0; phase_nxt = P_IDLE;
            end
          endcase
        end
      P_TX_WAIT_ACCEPT:
        if (dat) begin
          dclk_nxt = 1'b0; phase_nxt = P_TX_WAIT_READY; timer_nxt = '0;
        end else if (to) phase_nxt = P_ERR_WAIT;
      P_TX_WAIT_READY:
        if (!dat) begin
          phase_nxt = peoi_r ? P_TX_EOI_PAUSE : P_TX_PRE; timer_nxt = '0;
        end else if (to) phase_nxt = P_ERR_WAIT;
      P_TX_EOI_PAUSE:
        if (tinc >= 18'(cfg.eoi_signal_ticks)) begin
          phase_nxt = P_TX_EOI_LO; timer_nxt = '0;
        end
      P_TX_EOI_LO:
        if (dat) begin
          phase_nxt = P_TX_EOI_HI; timer_nxt = '0;
        end else if (to) phase_nxt = P_ERR_WAIT;
      P_TX_EOI_HI:
        if (!dat) begin
          phase_nxt = P_TX_PRE; timer_nxt = '0;
        end else if (to) phase_nxt = P_ERR_WAIT;
      P_TX_PRE:
        if (tinc >= 18'(cfg.no_eoi_ticks)) begin
          bitcnt_nxt = '0; dclk_nxt = 1'b1; ddat_nxt = ~shift_r[0];
          phase_nxt = P_TX_BIT_LO; timer_nxt = '0;
        end
      P_TX_BIT_LO:
        if (tinc >= 18'(cfg.bit_ticks)) begin
          dclk_nxt = 1'b0; phase_nxt = P_TX_BIT_HI; timer_nxt = '0;
        end
      P_TX_BIT_HI:
        if (tinc >= 18'(cfg.bit_ticks)) begin
          shift_nxt = {1'b0, shift_r[7:1]}; bitcnt_nxt = bc; timer_nxt = '0;
          if (bc < 4'd8) begin
            dclk_nxt = 1'b1; ddat_nxt = ~shift_r[1]; phase_nxt = P_TX_BIT_LO;
          end else begin
            dclk_nxt = 1'b1; ddat_nxt = 1'b0; phase_nxt = P_TX_STABLE;
          end
        end
      P_TX_STABLE:
        if (tinc >= 18'(cfg.stable_ticks)) begin
          phase_nxt = P_TX_WAIT_ACK; timer_nxt = '0;
        end
      P_TX_WAIT_ACK:
        if (dat) begin
          timer_nxt = '0;
          if (peoi_r) begin
            ddat_nxt = 1'b1; phase_nxt = P_UNDO_1;
          end else begin
            res.event_res = EV_SENT; phase_nxt = P_TALK_READY;
          end
        end else if (to) phase_nxt = P_ERR_WAIT;
      P_UNDO_1:
        if (tinc >= 18'(cfg.bit_ticks)) begin
          dclk_nxt = 1'b0; phase_nxt = P_UNDO_2; timer_nxt = '0;
        end
      P_UNDO_2:
        if (tinc >= 18'(cfg.bit_ticks)) begin
          phase_nxt = P_UNDO_WAIT; timer_nxt = '0;
        end
      P_UNDO_WAIT:
        if (lclk) begin
          res.event_res = EV_SENT; peoi_nxt = 1'b0; role_nxt = ROLE_IDLE;
          phase_nxt = P_IDLE; timer_nxt = '0;
        end else if (to) phase_nxt = P_ERR_WAIT;
      P_ERR_WAIT: begin
        dclk_nxt = 1'b0; ddat_nxt = 1'b0;
        if (!atn) begin
          res.event_res = EV_ERROR; role_nxt = ROLE_IDLE; phase_nxt = P_IDLE;
          timer_nxt = '0;
        end
      end
      default: begin
        dclk_nxt = 1'b0; ddat_nxt = 1'b0; role_nxt = ROLE_IDLE;
        phase_nxt = P_IDLE; timer_nxt = '0;
      end
    endcase
    // Error path: timeout or command overflow lands here this tick.
    if (phase_nxt == P_ERR_WAIT && phase_r != P_ERR_WAIT) begin
      dclk_nxt = 1'b0; ddat_nxt = 1'b0; role_nxt = ROLE_IDLE; timer_nxt = '0;
      if (!atn) begin
        res.event_res = EV_ERROR; phase_nxt = P_IDLE;
      end
    end
    res.drive_clock_low = dclk_nxt;
    res.drive_data_low  = ddat_nxt;
    res.secondary_code  = sec_nxt;
    res.busy_res        = (phase_nxt != P_TALK_READY);
  end

  // State update on each accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE; role_r <= ROLE_IDLE; post_role_r <= ROLE_IDLE;
      ctx_r <= CX_PRIMARY; shift_r <= '0; cmdlen_r <= '0; sec_r <= '0;
      bitcnt_r <= '0; timer_r <= '0; eoi_r <= 1'b0; atns_r <= 1'b0;
      peoi_r <= 1'b0; dclk_r <= 1'b0; ddat_r <= 1'b0; pev_r <= EV_NONE;
    end else if (step) begin
      phase_r <= phase_nxt; role_r <= role_nxt; post_role_r <= post_role_nxt;
      ctx_r <= ctx_nxt; shift_r <= shift_nxt; cmdlen_r <= cmdlen_nxt;
      sec_r <= sec_nxt; bitcnt_r <= bitcnt_nxt; timer_r <= timer_nxt;
      eoi_r <= eoi_nxt; atns_r <= atns_nxt; peoi_r <= peoi_nxt;
      dclk_r <= dclk_nxt; ddat_r <= ddat_nxt; pev_r <= pev_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (step) ov_r <= 1'b1;
    else if (!out_stall) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (step) out_r <= res;
  end

`ifndef NO_ASSERTIONS
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(step) |-> (out_r.busy_res == (phase_r != P_TALK_READY)))
    else $error("busy flag disagrees with phase");
  a_talk_drv: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == P_TALK_READY) |-> (dclk_r && !ddat_r))
    else $error("talker ready without clock held low");
  a_err_rel: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == P_ERR_WAIT) |-> (!dclk_r && !ddat_r && role_r == ROLE_IDLE))
    else $error("error wait with lines driven");
  a_rx_ev: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_r.rx_valid) |-> (out_r.event_res == EV_NONE))
    else $error("byte and event in the same beat");
`endif

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Serial bus device testbench
// Drives line-sample beats into the device engine and checks every output
// beat against a beat-level predictor of the bus protocol. Directed bus
// transactions (listen and talk, both with EOI) under one register setting
// are followed by random well-formed sequences mixed with line noise,
// commands and timeouts, under a second register setting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import iecdev_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;
  logic      psel;
  logic      penable;
  logic      pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  iec_serial_bus_device DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  localparam int CMD_LIMIT = CMD_MAX_LEN_DEF;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam int ITEM_BUDGET = 590;

  // Predictor state.
  cfg_t        regs;
  phase_t      ph;
  role_t       role;
  ctx_t        rx_ctx;
  logic [7:0]  sreg;
  logic [3:0]  nbits;
  logic [17:0] tmr;
  logic        eoi_flag;
  logic        atn_flag;
  logic [7:0]  cmd_len;
  logic [7:0]  sec_latch;
  logic        tx_eoi;
  logic        dclk;
  logic        ddat;
  logic [2:0]  post_ev;
  role_t       post_role;
  logic        cur_atn;
  out_beat_t   o;

  in_beat_t  sample_queue[$];
  out_beat_t expected_beats[$];

  int errors;
  int mismatches;
  int items_sent;
  int items_queued;
  int bytes_seen;
  int events_seen;
  int idle_cycles;
  logic stim_done;
  logic hold_off;
  logic in_taken;

  // ---------------------------------------------------------------------------
  // Predictor helpers.
  // ---------------------------------------------------------------------------
  function automatic void goto_phase(phase_t p);
    ph = p;
    tmr = '0;
  endfunction

  function automatic logic tick_done(logic [17:0] lim);
    if (tmr < TIMER_CAP) tmr = tmr + 18'd1;
    return tmr >= lim;
  endfunction

  function automatic void bus_fail();
    dclk = 1'b0;
    ddat = 1'b0;
    role = ROLE_IDLE;
    if (cur_atn) goto_phase(P_ERR_WAIT);
    else begin
      o.event_res = EV_ERROR;
      goto_phase(P_IDLE);
    end
  endfunction

  function automatic logic wait_line(logic cond);
    if (cond) return 1'b1;
    if (tick_done(regs.timeout_ticks)) bus_fail();
    return 1'b0;
  endfunction

  function automatic void begin_rx(ctx_t c);
    rx_ctx = c;
    eoi_flag = 1'b0;
    atn_flag = 1'b0;
    goto_phase(P_RX_WAIT_READY);
  endfunction

  function automatic void post_delay(logic [2:0] ev, role_t r);
    post_ev = ev;
    post_role = r;
    goto_phase(P_POST_DELAY);
  endfunction

  function automatic void begin_bits();
    atn_flag = cur_atn;
    nbits = '0;
    sreg = '0;
    goto_phase(P_RX_BIT_HIGH);
  endfunction

  function automatic void put_bit();
    dclk = 1'b1;
    ddat = ~sreg[0];
    goto_phase(P_TX_BIT_LO);
  endfunction

  function automatic void enter_attention();
    ddat = 1'b1;
    dclk = 1'b0;
    goto_phase(P_ATN_PRE);
  endfunction

  // A complete byte arrived; act on it according to the receive context.
  function automatic void byte_received(logic [7:0] c);
    case (rx_ctx)
      CX_PRIMARY: begin
        if (c == (CODE_LISTEN | {3'b000, regs.device_number})) begin_rx(CX_SEC_LISTEN);
        else if (c == (CODE_TALK | {3'b000, regs.device_number})) begin_rx(CX_SEC_TALK);
        else goto_phase(P_SKIP_DELAY);
      end
      CX_SEC_LISTEN: begin
        sec_latch = c;
        if ((c & CODE_HI_MASK) == CODE_DATA) post_delay(EV_LISTEN, ROLE_LISTEN);
        else if (c != CODE_UNLISTEN) begin
          cmd_len = '0;
          begin_rx(CX_COMMAND);
        end else post_delay(EV_NONE, ROLE_IDLE);
      end
      CX_SEC_TALK: begin
        sec_latch = c;
        goto_phase(P_TURN_WAIT);
      end
      CX_COMMAND: begin
        if (atn_flag && c == CODE_UNLISTEN) post_delay(EV_CMD, ROLE_IDLE);
        else if (cmd_len >= CMD_LIMIT) bus_fail();
        else begin
          cmd_len = cmd_len + 8'd1;
          o.rx_valid = 1'b1;
          o.rx_byte = c;
          o.rx_eoi = eoi_flag;
          o.rx_is_command = 1'b1;
          begin_rx(CX_COMMAND);
        end
      end
      default: begin
        o.rx_valid = 1'b1;
        o.rx_byte = c;
        o.rx_eoi = eoi_flag;
        o.rx_is_command = 1'b0;
        if (eoi_flag) begin
          role = ROLE_IDLE;
          goto_phase(P_IDLE);
        end else goto_phase(P_LISTEN_READY);
      end
    endcase
  endfunction

  function automatic void predictor_reset();
    regs = '{device_number: 5'd4, bit_ticks: 8'd70, eoi_detect_ticks: 10'd200,
             eoi_signal_ticks: 10'd200, no_eoi_ticks: 8'd20, stable_ticks: 8'd30,
             atn_delay_ticks: 10'd100, timeout_ticks: 18'd195000};
    ph = P_IDLE;
    role = ROLE_IDLE;
    rx_ctx = CX_PRIMARY;
    sreg = '0;
    nbits = '0;
    tmr = '0;
    eoi_flag = 1'b0;
    atn_flag = 1'b0;
    cmd_len = '0;
    sec_latch = '0;
    tx_eoi = 1'b0;
    dclk = 1'b0;
    ddat = 1'b0;
    post_ev = EV_NONE;
    post_role = ROLE_IDLE;
  endfunction

  // One line-sample tick of the device engine.
  function automatic out_beat_t bus_tick(in_beat_t s);
    logic lclk;
    logic ldat;
    lclk = s.clock_low;
    ldat = s.data_low;
    cur_atn = s.atn_low;
    o = '0;
    case (ph)
      P_IDLE: begin
        dclk = 1'b0;
        ddat = 1'b0;
        if (cur_atn) enter_attention();
      end
      P_LISTEN_READY: begin
        dclk = 1'b0;
        ddat = 1'b1;
        if (cur_atn) enter_attention();
        else if (!lclk) begin
          rx_ctx = CX_DATA;
          eoi_flag = 1'b0;
          atn_flag = 1'b0;
          ddat = 1'b0;
          goto_phase(P_RX_EOI_TIME);
        end
      end
      P_TALK_READY: begin
        dclk = 1'b1;
        ddat = 1'b0;
        if (cur_atn) enter_attention();
        else if (s.action == ACT_SEND || s.action == ACT_SEND_EOI) begin
          sreg = s.tx_byte;
          tx_eoi = (s.action == ACT_SEND_EOI);
          goto_phase(P_TX_WAIT_ACCEPT);
        end
      end
      P_ATN_PRE: if (tick_done(ATN_PRE_TICKS)) begin_rx(CX_PRIMARY);
      P_RX_WAIT_READY: if (wait_line(!lclk)) begin
        ddat = 1'b0;
        goto_phase(P_RX_EOI_TIME);
      end
      P_RX_EOI_TIME: begin
        if (lclk) begin_bits();
        else if (tick_done(18'(regs.eoi_detect_ticks))) begin
          eoi_flag = 1'b1;
          ddat = 1'b1;
          goto_phase(P_RX_EOI_ACK);
        end
      end
      P_RX_EOI_ACK: if (tick_done(18'(regs.bit_ticks))) begin
        ddat = 1'b0;
        goto_phase(P_RX_EOI_CLK);
      end
      P_RX_EOI_CLK: if (wait_line(lclk)) begin_bits();
      P_RX_BIT_HIGH: if (wait_line(!lclk)) begin
        sreg = {~ldat, sreg[7:1]};
        goto_phase(P_RX_BIT_LOW);
      end
      P_RX_BIT_LOW: if (wait_line(lclk)) begin
        nbits = nbits + 4'd1;
        if (nbits >= 4'd8) begin
          ddat = 1'b1;
          byte_received(sreg);
        end else goto_phase(P_RX_BIT_HIGH);
      end
      P_TURN_WAIT: if (wait_line(!lclk)) begin
        ddat = 1'b0;
        goto_phase(P_TURN_1);
      end
      P_TURN_1: if (tick_done(18'(regs.bit_ticks))) begin
        dclk = 1'b1;
        goto_phase(P_TURN_2);
      end
      P_TURN_2: if (tick_done(18'(regs.bit_ticks))) post_delay(EV_TALK, ROLE_TALK);
      P_SKIP_DELAY: if (tick_done(18'(regs.atn_delay_ticks))) begin
        dclk = 1'b0;
        ddat = 1'b0;
        goto_phase(P_SKIP_WAIT_ATN);
      end
      P_SKIP_WAIT_ATN: if (!cur_atn) begin
        role = ROLE_IDLE;
        post_delay(EV_NONE, ROLE_IDLE);
      end
      P_POST_DELAY: if (tick_done(18'(regs.atn_delay_ticks))) begin
        o.event_res = post_ev;
        role = post_role;
        if (role == ROLE_LISTEN) begin
          dclk = 1'b0;
          ddat = 1'b1;
          goto_phase(P_LISTEN_READY);
        end else if (role == ROLE_TALK) begin
          dclk = 1'b1;
          ddat = 1'b0;
          goto_phase(P_TALK_READY);
        end else begin
          dclk = 1'b0;
          ddat = 1'b0;
          goto_phase(P_IDLE);
        end
      end
      P_TX_WAIT_ACCEPT: if (wait_line(ldat)) begin
        dclk = 1'b0;
        goto_phase(P_TX_WAIT_READY);
      end
      P_TX_WAIT_READY: if (wait_line(!ldat))
        goto_phase(tx_eoi ? P_TX_EOI_PAUSE : P_TX_PRE);
      P_TX_EOI_PAUSE: if (tick_done(18'(regs.eoi_signal_ticks))) goto_phase(P_TX_EOI_LO);
      P_TX_EOI_LO: if (wait_line(ldat)) goto_phase(P_TX_EOI_HI);
      P_TX_EOI_HI: if (wait_line(!ldat)) goto_phase(P_TX_PRE);
      P_TX_PRE: if (tick_done(18'(regs.no_eoi_ticks))) begin
        nbits = '0;
        put_bit();
      end
      P_TX_BIT_LO: if (tick_done(18'(regs.bit_ticks))) begin
        dclk = 1'b0;
        goto_phase(P_TX_BIT_HI);
      end
      P_TX_BIT_HI: if (tick_done(18'(regs.bit_ticks))) begin
        sreg = sreg >> 1;
        nbits = nbits + 4'd1;
        if (nbits < 4'd8) put_bit();
        else begin
          dclk = 1'b1;
          ddat = 1'b0;
          goto_phase(P_TX_STABLE);
        end
      end
      P_TX_STABLE: if (tick_done(18'(regs.stable_ticks))) goto_phase(P_TX_WAIT_ACK);
      P_TX_WAIT_ACK: if (wait_line(ldat)) begin
        if (tx_eoi) begin
          ddat = 1'b1;
          goto_phase(P_UNDO_1);
        end else begin
          o.event_res = EV_SENT;
          goto_phase(P_TALK_READY);
        end
      end
      P_UNDO_1: if (tick_done(18'(regs.bit_ticks))) begin
        dclk = 1'b0;
        goto_phase(P_UNDO_2);
      end
      P_UNDO_2: if (tick_done(18'(regs.bit_ticks))) goto_phase(P_UNDO_WAIT);
      P_UNDO_WAIT: if (wait_line(lclk)) begin
        o.event_res = EV_SENT;
        tx_eoi = 1'b0;
        role = ROLE_IDLE;
        goto_phase(P_IDLE);
      end
      P_ERR_WAIT: begin
        dclk = 1'b0;
        ddat = 1'b0;
        if (!cur_atn) begin
          o.event_res = EV_ERROR;
          role = ROLE_IDLE;
          goto_phase(P_IDLE);
        end
      end
      default: begin
        dclk = 1'b0;
        ddat = 1'b0;
        role = ROLE_IDLE;
        goto_phase(P_IDLE);
      end
    endcase
    o.drive_clock_low = dclk;
    o.drive_data_low = ddat;
    o.secondary_code = sec_latch;
    o.busy_res = (ph != P_TALK_READY);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building: line samples as a bus controller would drive them.
  // ---------------------------------------------------------------------------
  function automatic void push_sample(logic a, logic c, logic d, logic [1:0] act,
                                      logic [7:0] b);
    in_beat_t s;
    s.atn_low = a;
    s.clock_low = c;
    s.data_low = d;
    s.action = act;
    s.tx_byte = b;
    sample_queue.push_back(s);
    items_queued = items_queued + 1;
  endfunction

  function automatic void push_hold(logic a, logic c, logic d, int n);
    for (int i = 0; i < n; i++) push_sample(a, c, d, 2'd0, 8'($urandom));
  endfunction

  // Controller sends one byte: ready release, optional EOI wait, eight bits,
  // then CLOCK held low. Timing is sized against the current registers.
  function automatic void send_byte(logic a, logic [7:0] b, logic eoi);
    push_hold(a, 1'b1, 1'b0, 2);
    if (eoi) begin
      push_hold(a, 1'b0, 1'b0, int'(regs.eoi_detect_ticks) + int'(regs.bit_ticks) + 3);
      push_hold(a, 1'b1, 1'b0, 2);
    end else begin
      push_hold(a, 1'b0, 1'b0, 1 + $urandom_range(0, 2));
    end
    for (int i = 0; i < 8; i++) begin
      push_hold(a, 1'b1, ~b[i], 1 + $urandom_range(0, 1));
      push_hold(a, 1'b0, ~b[i], 1 + $urandom_range(0, 1));
      push_hold(a, 1'b1, ~b[i], 1);
    end
    push_hold(a, 1'b1, 1'b0, 2);
  endfunction

  function automatic void atn_start();
    push_hold(1'b1, 1'b1, 1'b0, 55);
  endfunction

  function automatic void atn_release_wait();
    push_hold(1'b0, 1'b1, 1'b0, int'(regs.atn_delay_ticks) + 4);
  endfunction

  function automatic void open_listen(logic [7:0] sec);
    atn_start();
    send_byte(1'b1, CODE_LISTEN | {3'b000, regs.device_number}, 1'b0);
    send_byte(1'b1, sec, 1'b0);
    push_hold(1'b1, 1'b1, 1'b0, int'(regs.atn_delay_ticks) + 4);
    push_hold(1'b0, 1'b1, 1'b0, 3);
  endfunction

  function automatic void open_talk(logic [7:0] sec);
    atn_start();
    send_byte(1'b1, CODE_TALK | {3'b000, regs.device_number}, 1'b0);
    send_byte(1'b1, sec, 1'b0);
    push_hold(1'b0, 1'b0, 1'b0, 2 * int'(regs.bit_ticks) + int'(regs.atn_delay_ticks) + 6);
  endfunction

  // Controller as listener for one talked byte; the device then drives.
  function automatic void talk_byte(logic [7:0] b, logic eoi);
    int pause;
    push_sample(1'b0, 1'b0, 1'b1, eoi ? ACT_SEND_EOI : ACT_SEND, b);
    push_hold(1'b0, 1'b0, 1'b1, 3);
    push_hold(1'b0, 1'b0, 1'b0, 3);
    if (eoi) begin
      push_hold(1'b0, 1'b0, 1'b0, int'(regs.eoi_signal_ticks) + 2);
      push_hold(1'b0, 1'b0, 1'b1, 3);
      push_hold(1'b0, 1'b0, 1'b0, 2);
    end
    pause = int'(regs.no_eoi_ticks) + 16 * int'(regs.bit_ticks) +
            int'(regs.stable_ticks) + 4;
    push_hold(1'b0, 1'b0, 1'b0, pause);
    push_hold(1'b0, 1'b0, 1'b1, 2);
    if (eoi) begin
      push_hold(1'b0, 1'b0, 1'b1, 2 * int'(regs.bit_ticks) + 3);
      push_hold(1'b0, 1'b1, 1'b0, 3);
    end
  endfunction

  function automatic void random_sequence();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: begin
        open_listen(CODE_DATA | 8'($urandom_range(0, 15)));
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) send_byte(1'b0, 8'($urandom), i == n - 1);
      end
      2, 3: begin
        open_talk(CODE_DATA | 8'($urandom_range(0, 15)));
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) talk_byte(8'($urandom), 1'b0);
        talk_byte(8'($urandom), 1'b1);
      end
      4: begin
        open_listen(8'hF0 | 8'($urandom_range(0, 15)));
        atn_release_wait();
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) send_byte(1'b0, 8'($urandom), 1'b0);
        atn_start();
        send_byte(1'b1, CODE_UNLISTEN, 1'b0);
        push_hold(1'b1, 1'b1, 1'b0, int'(regs.atn_delay_ticks) + 4);
        push_hold(1'b0, 1'b0, 1'b0, 3);
      end
      5: begin
        atn_start();
        send_byte(1'b1, 8'($urandom), 1'b0);
        push_hold(1'b1, 1'b1, 1'b0, int'(regs.atn_delay_ticks) + 3);
        atn_release_wait();
      end
      6: begin
        // Noise on all lines, sends included.
        n = $urandom_range(5, 40);
        for (int i = 0; i < n; i++)
          push_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 2'($urandom), 8'($urandom));
        push_hold(1'b0, 1'b0, 1'b0, 1);
      end
      default: begin
        // Broken sequence: start a byte under attention and abandon it mid-byte.
        atn_start();
        push_hold(1'b1, 1'b1, 1'b0, 2);
        push_hold(1'b1, 1'b0, 1'b0, 2);
        push_hold(1'b1, 1'b1, 1'b1, 1);
        push_hold(1'b1, 1'b0, 1'b1, int'(regs.timeout_ticks) + 3);
        push_hold(1'b0, 1'b0, 1'b0, 3);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and reset.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Remember whether the input beat was taken at the last rising edge.
  always @(posedge clk) begin
    if (!rst_n) in_taken <= 1'b0;
    else in_taken <= in_valid && !in_stall;
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of beats with random gaps, changes at falling edges.
  // ---------------------------------------------------------------------------
  int burst_left;
  int gap_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (in_valid && !in_taken) begin
      // hold the stalled beat
    end else begin
      if (in_valid) begin
        expected_beats.push_back(bus_tick(in_data));
        items_sent <= items_sent + 1;
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (sample_queue.size() > 0) begin
        in_data <= sample_queue.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 60);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        end else burst_left <= burst_left - 1;
      end else in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall pattern, with one long hold-off.
  // ---------------------------------------------------------------------------
  int stall_phase;
  int hold_count;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_phase <= 0;
      hold_count <= 0;
    end else if (hold_off) begin
      out_stall <= (hold_count < 200);
      hold_count <= hold_count + 1;
    end else begin
      stall_phase <= (stall_phase + 1) % 97;
      if (stall_phase < 40) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 2) == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares each output beat with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          errors <= errors + 1;
          $display("ERROR: output beat with nothing expected: %h", out_data);
        end else begin
          if (out_data !== expected_beats[0]) begin
            errors <= errors + 1;
            if (mismatches < 10)
              $display("ERROR: beat mismatch: expected %h, got %h",
                       expected_beats[0], out_data);
            mismatches <= mismatches + 1;
          end
          if (expected_beats[0].rx_valid) bytes_seen <= bytes_seen + 1;
          if (expected_beats[0].event_res != EV_NONE) events_seen <= events_seen + 1;
          void'(expected_beats.pop_front());
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Register writes and phases.
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DEVNUM:  regs.device_number = val[4:0];
      REG_BIT:     regs.bit_ticks = val[7:0];
      REG_EOI_DET: regs.eoi_detect_ticks = val[9:0];
      REG_EOI_SIG: regs.eoi_signal_ticks = val[9:0];
      REG_NO_EOI:  regs.no_eoi_ticks = val[7:0];
      REG_STABLE:  regs.stable_ticks = val[7:0];
      REG_ATN_DLY: regs.atn_delay_ticks = val[9:0];
      default:     regs.timeout_ticks = val[17:0];
    endcase
  endtask

  task automatic drain();
    while (sample_queue.size() > 0 || in_valid || expected_beats.size() > 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic set_all(logic [4:0] dev, logic [7:0] bt, logic [9:0] ed, logic [9:0] es,
                         logic [7:0] ne, logic [7:0] st, logic [9:0] ad, logic [17:0] to);
    write_reg(REG_DEVNUM, 32'(dev));
    write_reg(REG_BIT, 32'(bt));
    write_reg(REG_EOI_DET, 32'(ed));
    write_reg(REG_EOI_SIG, 32'(es));
    write_reg(REG_NO_EOI, 32'(ne));
    write_reg(REG_STABLE, 32'(st));
    write_reg(REG_ATN_DLY, 32'(ad));
    write_reg(REG_TIMEOUT, 32'(to));
  endtask

  // Random sequences until the run has queued its share of beats.
  task automatic random_phase();
    while (items_queued < ITEM_BUDGET) random_sequence();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    mismatches = 0;
    items_sent = 0;
    items_queued = 0;
    bytes_seen = 0;
    events_seen = 0;
    idle_cycles = 0;
    stim_done = 1'b0;
    hold_off = 1'b0;
    predictor_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Short timings so that whole transactions fit in a few hundred beats.
    set_all(5'd4, 8'd3, 10'd12, 10'd6, 8'd2, 8'd2, 10'd4, 18'd40);

    // Directed: listen with data and EOI, talk with EOI undo.
    open_listen(8'h60);
    send_byte(1'b0, 8'h00, 1'b0);
    send_byte(1'b0, 8'hFF, 1'b1);
    open_talk(8'h6F);
    talk_byte(8'h5A, 1'b1);

    // Long receiver hold-off while the driver keeps offering beats.
    hold_off = 1'b1;
    drain();
    hold_off = 1'b0;

    // Extreme settings: device number 30, minimal delays.
    set_all(5'd30, 8'd1, 10'd1, 10'd1, 8'd1, 8'd1, 10'd1, 18'd20);
    random_phase();
    drain();

    stim_done = 1'b1;
    repeat (10) @(posedge clk);

    $display("Covered %0d sample beats, %0d received bytes and %0d bus events.",
             items_sent, bytes_seen, events_seen);
    if (errors == 0 && expected_beats.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // Watchdog on cycles without any beat moving.
  always @(posedge clk) begin
    if (rst_n && !stim_done && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: timeout, no beat moved for %0d cycles", idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
